// File: rtl/core/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, widths and register codes for the vertex rotate/project core.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int COORD_BITS = 16;
  localparam int TRIG_W     = 16;
  localparam int FRAC_W     = 14;
  localparam int ANGLE_W    = 10;
  localparam int FOV_W      = 15;
  localparam int DIM_W      = 13;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;

  localparam int ROT_W  = COORD_BITS + 2;
  localparam int DIST_W = ((ROT_W > FOV_W + 1) ? ROT_W : FOV_W + 1) + 1;
  localparam int XF_W   = ROT_W + FOV_W + 1;
  localparam int WD_W   = DIST_W + DIM_W + 1;
  localparam int NUM_W  = ((XF_W + 1 > WD_W) ? XF_W + 1 : WD_W) + 1;
  localparam int DEN_W  = DIST_W;

  localparam logic [FOV_W-1:0] FOV_RST    = FOV_W'(256);
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE  = 2'd0,
    CFG_FOV    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] screen_x;
    logic signed [COORD_BITS-1:0] screen_y;
    logic                         behind_camera;
  } out_beat_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
  } div_lane_t;

endpackage

// File: rtl/core/vertex_rotate_project.sv
// Pipeline: 1 input, 4 rotation, 3 projection, 36 divider stages and 1 output
//   register lie between an accepted input beat and out_valid.
// Throughput: one beat per cycle; the whole pipeline stalls only while
//   out_valid is high and out_ready is low.
// Reset: synchronous, active low; clears all valid bits and loads register
//   defaults (angle 0, fov 256, width 640, height 480).
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Rotates each point about X then Y and projects it onto the screen.
// ----------------------------------------------------------------------------
module vertex_rotate_project
  import vrp_pkg::*;
#(
  parameter int ANGLE_STEPS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_beat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [FOV_W-1:0] fov_r, fov_nxt;
  logic [DIM_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic             angle_we;

  logic                     en;
  logic signed [TRIG_W-1:0] sin_r, cos_r;
  logic                     rot_vld;
  logic signed [ROT_W-1:0]  x2, y2, z2;
  logic                     prj_vld, neg_x, neg_y, behind;
  logic [NUM_W-1:0]         mag_x, mag_y;
  logic [DEN_W-1:0]         den;
  logic                     div_vld;
  out_beat_t                div_beat;
  logic                     out_vld_r;
  out_beat_t                out_beat_r;

  always_comb begin
    fov_nxt    = fov_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    angle_we   = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_ANGLE:  angle_we   = 1'b1;
        CFG_FOV:    fov_nxt    = cfg_wdata[FOV_W-1:0];
        CFG_WIDTH:  width_nxt  = cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: height_nxt = cfg_wdata[DIM_W-1:0];
        default:    angle_we   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fov_r    <= FOV_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      fov_r    <= fov_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign en       = ~out_vld_r | out_ready;
  assign in_ready = en;

  vrp_trig #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_trig (
    .clk        (clk),
    .rst_n      (rst_n),
    .angle_we   (angle_we),
    .angle_wdata(cfg_wdata[ANGLE_W-1:0]),
    .sin_r      (sin_r),
    .cos_r      (cos_r)
  );

  vrp_rotate u_rotate (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .in_beat(in_beat),
    .sin_q  (sin_r),
    .cos_q  (cos_r),
    .vld_r  (rot_vld),
    .x2_r   (x2),
    .y2_r   (y2),
    .z2_r   (z2)
  );

  vrp_project u_project (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (rot_vld),
    .x2      (x2),
    .y2      (y2),
    .z2      (z2),
    .fov     (fov_r),
    .width   (width_r),
    .height  (height_r),
    .vld_r   (prj_vld),
    .mag_x_r (mag_x),
    .mag_y_r (mag_y),
    .neg_x_r (neg_x),
    .neg_y_r (neg_y),
    .den_r   (den),
    .behind_r(behind)
  );

  vrp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(prj_vld),
    .mag_x (mag_x),
    .mag_y (mag_y),
    .neg_x (neg_x),
    .neg_y (neg_y),
    .den   (den),
    .behind(behind),
    .vld   (div_vld),
    .beat  (div_beat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= div_beat;
    end
  end

  assign out_valid = out_vld_r;
  assign out_beat  = out_beat_r;

endmodule

// File: rtl/core/vrp_trig.sv
// ----------------------------------------------------------------------------
// vrp_trig
// Angle register reduced to quadrant and offset, quarter-wave sine table,
// registered Q1.14 sine and cosine.
// ----------------------------------------------------------------------------
module vrp_trig
  import vrp_pkg::*;
#(
  parameter int ANGLE_STEPS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     angle_we,
  input  logic [ANGLE_W-1:0]       angle_wdata,
  output logic signed [TRIG_W-1:0] sin_r,
  output logic signed [TRIG_W-1:0] cos_r
);

  localparam int QUARTER = ANGLE_STEPS / 4;
  localparam int IW      = $clog2(QUARTER + 1);
  localparam int RECIP   = (1 << 20) / QUARTER + 1;
  localparam int PROD_W  = ANGLE_W + 18;

  logic [TRIG_W-2:0] rom [0:QUARTER];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    localparam logic [63:0] X  = (64'd1686629713 * 64'(k)) / 64'(QUARTER);
    localparam logic [63:0] T1 = ((((X * X) >> 30) * X) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 64'd156;
    localparam logic [63:0] T7 = ((((T6 * X) >> 30) * X) >> 30) / 64'd210;
    localparam logic signed [63:0] S = $signed(X) - $signed(T1) + $signed(T2)
                                     - $signed(T3) + $signed(T4) - $signed(T5)
                                     + $signed(T6) - $signed(T7);
    localparam logic signed [63:0] E = (S < 0) ? 64'sd0 : ((S + 64'sd32768) >>> 16);
    assign rom[k] = E[TRIG_W-2:0];
  end

  logic [1:0]          quad_r, quad_nxt;
  logic [IW-1:0]       ofs_r, ofs_nxt;
  logic [PROD_W-1:0]   prod;
  logic [6:0]          qfull;
  logic [ANGLE_W:0]    base;
  logic [ANGLE_W-1:0]  ofs_full;
  logic signed [TRIG_W-1:0] t_lo, t_hi, sin_nxt, cos_nxt;

  // angle / quarter by reciprocal, exact for 10-bit angles
  always_comb begin
    prod     = PROD_W'(angle_wdata) * PROD_W'(RECIP);
    qfull    = prod[26:20];
    base     = (ANGLE_W + 1)'(int'(qfull) * QUARTER);
    ofs_full = angle_wdata - base[ANGLE_W-1:0];
    quad_nxt = angle_we ? qfull[1:0] : quad_r;
    ofs_nxt  = angle_we ? IW'(ofs_full) : ofs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r <= '0;
      ofs_r  <= '0;
    end else begin
      quad_r <= quad_nxt;
      ofs_r  <= ofs_nxt;
    end
  end

  always_comb begin
    t_lo = $signed({1'b0, rom[ofs_r]});
    t_hi = $signed({1'b0, rom[IW'(QUARTER) - ofs_r]});
    case (quad_e'(quad_r))
      QUAD_0: begin
        sin_nxt = t_lo;
        cos_nxt = t_hi;
      end
      QUAD_1: begin
        sin_nxt = t_hi;
        cos_nxt = -t_lo;
      end
      QUAD_2: begin
        sin_nxt = -t_lo;
        cos_nxt = -t_hi;
      end
      QUAD_3: begin
        sin_nxt = -t_hi;
        cos_nxt = t_lo;
      end
      default: begin
        sin_nxt = t_lo;
        cos_nxt = t_hi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

endmodule

// File: rtl/core/vrp_rotate.sv
// ----------------------------------------------------------------------------
// vrp_rotate
// Five-stage rotation about X then Y with Q1.14 rounding between passes.
// ----------------------------------------------------------------------------
module vrp_rotate
  import vrp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  in_beat_t                 in_beat,
  input  logic signed [TRIG_W-1:0] sin_q,
  input  logic signed [TRIG_W-1:0] cos_q,
  output logic                     vld_r,
  output logic signed [ROT_W-1:0]  x2_r,
  output logic signed [ROT_W-1:0]  y2_r,
  output logic signed [ROT_W-1:0]  z2_r
);

  localparam int P1 = COORD_BITS + TRIG_W;
  localparam int S1 = P1 + 1;
  localparam int P2 = ROT_W + TRIG_W;
  localparam int S2 = P2 + 1;

  logic [3:0] v_r;

  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r, x1a_r, x1b_r;
  logic signed [P1-1:0] yc_r, zs_r, ys_r, zc_r;
  logic signed [ROT_W-1:0] y1_r, z1_r, y1b_r;
  logic signed [P2-1:0] cx_r, sz_r, sx_r, cz_r;
  logic signed [S1-1:0] y1_sum, z1_sum;
  logic signed [S2-1:0] x2_sum, z2_sum;
  logic signed [S1-1:0] y1_sh, z1_sh;
  logic signed [S2-1:0] x2_sh, z2_sh;

  always_comb begin
    y1_sum = S1'(yc_r) - S1'(zs_r) + S1'(1 << (FRAC_W - 1));
    z1_sum = S1'(ys_r) + S1'(zc_r) + S1'(1 << (FRAC_W - 1));
    y1_sh  = y1_sum >>> FRAC_W;
    z1_sh  = z1_sum >>> FRAC_W;
    x2_sum = S2'(cx_r) - S2'(sz_r) + S2'(1 << (FRAC_W - 1));
    z2_sum = S2'(sx_r) + S2'(cz_r) + S2'(1 << (FRAC_W - 1));
    x2_sh  = x2_sum >>> FRAC_W;
    z2_sh  = z2_sum >>> FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      vld_r <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[2:0], in_vld};
      vld_r <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= in_beat.point_x;
      py_r  <= in_beat.point_y;
      pz_r  <= in_beat.point_z;
      // about X
      yc_r  <= P1'(py_r) * P1'(cos_q);
      zs_r  <= P1'(pz_r) * P1'(sin_q);
      ys_r  <= P1'(py_r) * P1'(sin_q);
      zc_r  <= P1'(pz_r) * P1'(cos_q);
      x1a_r <= px_r;
      y1_r  <= y1_sh[ROT_W-1:0];
      z1_r  <= z1_sh[ROT_W-1:0];
      x1b_r <= x1a_r;
      // about Y
      cx_r  <= P2'(x1b_r) * P2'(cos_q);
      sz_r  <= P2'(z1_r) * P2'(sin_q);
      sx_r  <= P2'(x1b_r) * P2'(sin_q);
      cz_r  <= P2'(z1_r) * P2'(cos_q);
      y1b_r <= y1_r;
      x2_r  <= x2_sh[ROT_W-1:0];
      z2_r  <= z2_sh[ROT_W-1:0];
      y2_r  <= y1b_r;
    end
  end

endmodule

// File: rtl/core/vrp_project.sv
// ----------------------------------------------------------------------------
// vrp_project
// Three-stage build of the perspective numerators and denominator.
// ----------------------------------------------------------------------------
module vrp_project
  import vrp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [ROT_W-1:0] x2,
  input  logic signed [ROT_W-1:0] y2,
  input  logic signed [ROT_W-1:0] z2,
  input  logic [FOV_W-1:0]        fov,
  input  logic [DIM_W-1:0]        width,
  input  logic [DIM_W-1:0]        height,
  output logic                    vld_r,
  output logic [NUM_W-1:0]        mag_x_r,
  output logic [NUM_W-1:0]        mag_y_r,
  output logic                    neg_x_r,
  output logic                    neg_y_r,
  output logic [DEN_W-1:0]        den_r,
  output logic                    behind_r
);

  logic [1:0] v_r;
  logic signed [DIST_W-1:0] d_r, d2_r, d_nxt;
  logic signed [XF_W-1:0]   xf_r, yf_r, xf2_r, yf2_r;
  logic signed [WD_W-1:0]   wd_r, hd_r;
  logic                     bh_r, bh2_r;
  logic signed [NUM_W-1:0]  num_x, num_y;

  always_comb begin
    d_nxt = DIST_W'(z2) + DIST_W'($signed({1'b0, fov}));
    num_x = (NUM_W'(xf2_r) <<< 1) + NUM_W'(wd_r);
    num_y = (NUM_W'(yf2_r) <<< 1) + NUM_W'(hd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      vld_r <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[0], in_vld};
      vld_r <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= d_nxt;
      bh_r     <= d_nxt[DIST_W-1] | (d_nxt == '0);
      xf_r     <= XF_W'(x2) * XF_W'($signed({1'b0, fov}));
      yf_r     <= XF_W'(y2) * XF_W'($signed({1'b0, fov}));
      wd_r     <= WD_W'(d_r) * WD_W'($signed({1'b0, width}));
      hd_r     <= WD_W'(d_r) * WD_W'($signed({1'b0, height}));
      xf2_r    <= xf_r;
      yf2_r    <= yf_r;
      d2_r     <= d_r;
      bh2_r    <= bh_r;
      neg_x_r  <= num_x[NUM_W-1];
      neg_y_r  <= num_y[NUM_W-1];
      mag_x_r  <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      mag_y_r  <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
      den_r    <= {d2_r[DIST_W-2:0], 1'b0};
      behind_r <= bh2_r;
    end
  end

endmodule

// File: rtl/core/vrp_div.sv
// ----------------------------------------------------------------------------
// vrp_div
// Pipelined restoring divider, one quotient bit per stage for both lanes,
// followed by sign restore and saturation.
// ----------------------------------------------------------------------------
module vrp_div
  import vrp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] mag_x,
  input  logic [NUM_W-1:0] mag_y,
  input  logic             neg_x,
  input  logic             neg_y,
  input  logic [DEN_W-1:0] den,
  input  logic             behind,
  output logic             vld,
  output out_beat_t        beat
);

  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(1 << (COORD_BITS - 1));

  function automatic div_lane_t div_step(div_lane_t cur, logic [DEN_W-1:0] dv);
    logic [DEN_W:0] trial;
    div_lane_t      res;
    trial = {cur.rem, cur.num[NUM_W-1]};
    if (trial >= {1'b0, dv}) begin
      res.rem = DEN_W'(trial - {1'b0, dv});
      res.num = {cur.num[NUM_W-2:0], 1'b1};
    end else begin
      res.rem = trial[DEN_W-1:0];
      res.num = {cur.num[NUM_W-2:0], 1'b0};
    end
    return res;
  endfunction

  logic             vld_r    [NUM_W];
  div_lane_t        lx_r     [NUM_W];
  div_lane_t        ly_r     [NUM_W];
  logic [DEN_W-1:0] den_r    [NUM_W];
  logic             negx_r   [NUM_W];
  logic             negy_r   [NUM_W];
  logic             behind_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    div_lane_t        lx_in, ly_in;
    logic [DEN_W-1:0] den_in;
    logic             vld_in, negx_in, negy_in, behind_in;

    if (i == 0) begin : g_head
      always_comb begin
        lx_in     = '{num: mag_x, rem: '0};
        ly_in     = '{num: mag_y, rem: '0};
        den_in    = den;
        vld_in    = in_vld;
        negx_in   = neg_x;
        negy_in   = neg_y;
        behind_in = behind;
      end
    end else begin : g_body
      always_comb begin
        lx_in     = lx_r[i-1];
        ly_in     = ly_r[i-1];
        den_in    = den_r[i-1];
        vld_in    = vld_r[i-1];
        negx_in   = negx_r[i-1];
        negy_in   = negy_r[i-1];
        behind_in = behind_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lx_r[i]     <= div_step(lx_in, den_in);
        ly_r[i]     <= div_step(ly_in, den_in);
        den_r[i]    <= den_in;
        negx_r[i]   <= negx_in;
        negy_r[i]   <= negy_in;
        behind_r[i] <= behind_in;
      end
    end
  end

  logic [NUM_W-1:0]      qx, qy;
  logic [COORD_BITS-1:0] sx, sy;

  always_comb begin
    qx = lx_r[NUM_W-1].num;
    qy = ly_r[NUM_W-1].num;
    if (negx_r[NUM_W-1]) begin
      sx = (qx > NEG_MAX) ? NEG_MAX[COORD_BITS-1:0] : COORD_BITS'(~qx + 1'b1);
    end else begin
      sx = (qx > POS_MAX) ? POS_MAX[COORD_BITS-1:0] : qx[COORD_BITS-1:0];
    end
    if (negy_r[NUM_W-1]) begin
      sy = (qy > NEG_MAX) ? NEG_MAX[COORD_BITS-1:0] : COORD_BITS'(~qy + 1'b1);
    end else begin
      sy = (qy > POS_MAX) ? POS_MAX[COORD_BITS-1:0] : qy[COORD_BITS-1:0];
    end
    vld                = vld_r[NUM_W-1];
    beat.behind_camera = behind_r[NUM_W-1];
    beat.screen_x      = behind_r[NUM_W-1] ? '0 : $signed(sx);
    beat.screen_y      = behind_r[NUM_W-1] ? '0 : $signed(sy);
  end

endmodule
